/* hw/rtl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared widths, token codes and status codes of the RPN evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    localparam int DATA_W      = 64;
    localparam int CNT_W       = 6;    // width of the iteration counter of the shared mul/div loop

    typedef logic [2:0] opcode_t;
    typedef logic [2:0] status_t;

    localparam opcode_t OP_PUSH   = 3'd0;
    localparam opcode_t OP_ADD    = 3'd1;
    localparam opcode_t OP_SUB    = 3'd2;
    localparam opcode_t OP_MUL    = 3'd3;
    localparam opcode_t OP_DIV    = 3'd4;
    localparam opcode_t OP_FINISH = 3'd5;

    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_UNDER = 3'd1;
    localparam status_t ST_OVER  = 3'd2;
    localparam status_t ST_DIVZ  = 3'd3;
    localparam status_t ST_BAD   = 3'd4;
    localparam status_t ST_DEPTH = 3'd5;
    localparam status_t ST_FULL  = 3'd6;

    localparam logic [3:0] MAX_DIGIT = 4'd9;

    localparam logic [DATA_W-1:0] SIGN64 = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

/* hw/rtl/rpn_ram.sv */
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rpn_stack_evaluator_top.sv */
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top
// Signed 64-bit reverse Polish evaluator, one token per input transaction.
// ----------------------------------------------------------------------------
// Push, finish, bad token and tokens after an error: registered from idle.
//   + and -: one RAM read of the second operand, then the result.
//   * and /: RAM read, 64-step shift-add / restoring-divide loop, fix-up;
//   divide by zero and divide overflow stop after the RAM read. One token at
//   a time: the next token is taken once idle and the result register is free.
// Reset (rst_n, async): stack empty, no error, output empty. RAM not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] digit, [7:4] zero
    input  wire logic [2:0]  s_tuser,   // [2:0] operation

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // [63:0] value
    output logic             m_tlast,   // done_res
    output logic      [2:0]  m_tuser    // [2:0] status
);

    // One-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,  // second operand arriving from RAM
        S_ITER = 4'b0100,  // shared multiply/divide loop
        S_FIN  = 4'b1000   // sign fix-up, multiply overflow check
    } state_t;

    state_t state_reg, state_next;

    // Top of stack lives in tos_reg; RAM holds the entries below it,
    // so an operator needs just one RAM read and no write.
    logic [rpn_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [rpn_pkg::DATA_W-1:0]  tos_reg, tos_next;
    rpn_pkg::status_t            err_reg, err_next;
    rpn_pkg::opcode_t            op_reg, op_next;

    // Iterative unit
    logic                        neg_reg, neg_next;
    logic [rpn_pkg::DATA_W-1:0]  mb_reg, mb_next;
    logic [rpn_pkg::DATA_W:0]    acc_reg, acc_next;
    logic [rpn_pkg::DATA_W-1:0]  q_reg, q_next;
    logic [rpn_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    rpn_pkg::status_t            out_status_reg, out_status_next;
    logic                        out_last_reg, out_last_next;
    logic [rpn_pkg::DATA_W-1:0]  out_value_reg, out_value_next;

    // RAM port
    logic                        wr_en, rd_en;
    logic [rpn_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
    logic [rpn_pkg::DATA_W-1:0]  rd_data;

    logic                        s_accept;
    logic [rpn_pkg::DEPTH_W-1:0] depth_m1, depth_m2;

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    assign depth_m1 = depth_reg - rpn_pkg::DEPTH_W'(1);
    assign depth_m2 = depth_reg - rpn_pkg::DEPTH_W'(2);
    assign wr_addr  = depth_m1[rpn_pkg::ADDR_W-1:0];
    assign rd_addr  = depth_m2[rpn_pkg::ADDR_W-1:0];

    rpn_ram #(
        .WIDTH (rpn_pkg::DATA_W),
        .DEPTH (rpn_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (tos_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        logic [rpn_pkg::DATA_W-1:0] a;
        logic [rpn_pkg::DATA_W-1:0] b;
        logic [rpn_pkg::DATA_W-1:0] s;
        logic [rpn_pkg::DATA_W-1:0] lim;
        logic [rpn_pkg::DATA_W-1:0] res;
        logic [rpn_pkg::DATA_W:0]   sum;
        logic [rpn_pkg::DATA_W:0]   t;
        logic                       ovf;

        state_next      = state_reg;
        depth_next      = depth_reg;
        tos_next        = tos_reg;
        err_next        = err_reg;
        op_next         = op_reg;
        neg_next        = neg_reg;
        mb_next         = mb_reg;
        acc_next        = acc_reg;
        q_next          = q_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_value_next  = out_value_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        a   = rd_data;
        b   = tos_reg;
        s   = '0;
        sum = '0;
        t   = '0;
        ovf = 1'b0;
        lim = neg_reg ? rpn_pkg::SIGN64 : (rpn_pkg::SIGN64 - rpn_pkg::DATA_W'(1));
        res = neg_reg ? (~q_reg + rpn_pkg::DATA_W'(1)) : q_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    // Non-finish results: status is the sticky code after the token
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b0;
                    out_value_next  = '0;
                    out_status_next = err_reg;
                    if (s_tuser == rpn_pkg::OP_FINISH)
                    begin
                        out_last_next = 1'b1;
                        if (err_reg == rpn_pkg::ST_OK)
                        begin
                            if (depth_reg == rpn_pkg::DEPTH_W'(1))
                            begin
                                out_value_next = tos_reg;
                            end
                            else
                            begin
                                out_status_next = rpn_pkg::ST_DEPTH;
                            end
                        end
                        depth_next = '0;
                        err_next   = rpn_pkg::ST_OK;
                    end
                    else if (err_reg == rpn_pkg::ST_OK)
                    begin
                        case (s_tuser)
                            rpn_pkg::OP_PUSH:
                            begin
                                if (s_tdata[3:0] > rpn_pkg::MAX_DIGIT)
                                begin
                                    err_next        = rpn_pkg::ST_BAD;
                                    out_status_next = rpn_pkg::ST_BAD;
                                end
                                else if (depth_reg ==
                                         rpn_pkg::DEPTH_W'(rpn_pkg::STACK_DEPTH))
                                begin
                                    err_next        = rpn_pkg::ST_FULL;
                                    out_status_next = rpn_pkg::ST_FULL;
                                end
                                else
                                begin
                                    // spill old top into RAM
                                    wr_en      = (depth_reg != '0);
                                    tos_next   = {{(rpn_pkg::DATA_W-4){1'b0}}, s_tdata[3:0]};
                                    depth_next = depth_reg + rpn_pkg::DEPTH_W'(1);
                                end
                            end
                            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB,
                            rpn_pkg::OP_MUL, rpn_pkg::OP_DIV:
                            begin
                                if (depth_reg < rpn_pkg::DEPTH_W'(2))
                                begin
                                    err_next        = rpn_pkg::ST_UNDER;
                                    out_status_next = rpn_pkg::ST_UNDER;
                                end
                                else
                                begin
                                    // result goes out later
                                    out_valid_next = 1'b0;
                                    rd_en          = 1'b1;
                                    op_next        = s_tuser;
                                    state_next     = S_READ;
                                end
                            end
                            default:
                            begin
                                err_next        = rpn_pkg::ST_BAD;
                                out_status_next = rpn_pkg::ST_BAD;
                            end
                        endcase
                    end
                end
            end

            S_READ:
            begin
                out_last_next   = 1'b0;
                out_value_next  = '0;
                out_status_next = rpn_pkg::ST_OK;
                neg_next        = a[rpn_pkg::DATA_W-1] ^ b[rpn_pkg::DATA_W-1];
                q_next          = a[rpn_pkg::DATA_W-1] ? (~a + rpn_pkg::DATA_W'(1)) : a;
                mb_next         = b[rpn_pkg::DATA_W-1] ? (~b + rpn_pkg::DATA_W'(1)) : b;
                acc_next        = '0;
                cnt_next        = '1;
                case (op_reg)
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB:
                    begin
                        if (op_reg == rpn_pkg::OP_ADD)
                        begin
                            s   = a + b;
                            ovf = ((a ^ s) & (b ^ s) & rpn_pkg::SIGN64) != '0;
                        end
                        else
                        begin
                            s   = a - b;
                            ovf = ((a ^ b) & (a ^ s) & rpn_pkg::SIGN64) != '0;
                        end
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                        if (ovf)
                        begin
                            err_next        = rpn_pkg::ST_OVER;
                            out_status_next = rpn_pkg::ST_OVER;
                        end
                        else
                        begin
                            tos_next   = s;
                            depth_next = depth_m1;
                        end
                    end
                    rpn_pkg::OP_DIV:
                    begin
                        if (b == '0)
                        begin
                            err_next        = rpn_pkg::ST_DIVZ;
                            out_status_next = rpn_pkg::ST_DIVZ;
                            out_valid_next  = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if ((a == rpn_pkg::SIGN64) && (b == '1))
                        begin
                            err_next        = rpn_pkg::ST_OVER;
                            out_status_next = rpn_pkg::ST_OVER;
                            out_valid_next  = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_ITER;
                        end
                    end
                    default:
                    begin
                        state_next = S_ITER;
                    end
                endcase
            end

            S_ITER:
            begin
                if (op_reg == rpn_pkg::OP_MUL)
                begin
                    // shift-add: {acc, q} holds the growing 128-bit product
                    sum = {1'b0, acc_reg[rpn_pkg::DATA_W-1:0]}
                        + (q_reg[0] ? {1'b0, mb_reg} : '0);
                    acc_next = {1'b0, sum[rpn_pkg::DATA_W:1]};
                    q_next   = {sum[0], q_reg[rpn_pkg::DATA_W-1:1]};
                end
                else
                begin
                    // restoring divide, one quotient bit per cycle
                    t = {acc_reg[rpn_pkg::DATA_W-1:0], q_reg[rpn_pkg::DATA_W-1]};
                    if (t >= {1'b0, mb_reg})
                    begin
                        acc_next = t - {1'b0, mb_reg};
                        q_next   = {q_reg[rpn_pkg::DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = t;
                        q_next   = {q_reg[rpn_pkg::DATA_W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg - rpn_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                ovf = (op_reg == rpn_pkg::OP_MUL) &&
                      ((acc_reg[rpn_pkg::DATA_W-1:0] != '0) || (q_reg > lim));
                if (ovf)
                begin
                    err_next        = rpn_pkg::ST_OVER;
                    out_status_next = rpn_pkg::ST_OVER;
                end
                else
                begin
                    tos_next   = res;
                    depth_next = depth_m1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= rpn_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg        <= tos_next;
        op_reg         <= op_next;
        neg_reg        <= neg_next;
        mb_reg         <= mb_next;
        acc_reg        <= acc_next;
        q_reg          <= q_next;
        cnt_reg        <= cnt_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_value_reg  <= out_value_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= rpn_pkg::DEPTH_W'(rpn_pkg::STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (s_tuser == rpn_pkg::OP_FINISH)
        |=> (depth_reg == '0) && (err_reg == rpn_pkg::ST_OK))
        else $error("finish did not clear stack");

    a_err_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != rpn_pkg::ST_OK) && !(s_accept && (s_tuser == rpn_pkg::OP_FINISH))
        |=> $stable(depth_reg))
        else $error("stack moved while error set");

    a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER) |-> !out_valid_reg)
        else $error("result pending during mul/div loop");

endmodule

`default_nettype wire
